// ----- rtl/kal_pkg.sv -----
// Shared types, constants and round functions of the Kalyna-128/128 encryption pipeline.
// Standalone: used by kal_stage and kalyna_128_block_encrypt.
package kal_pkg;

  localparam int ROUNDS = 10;
  localparam logic [7:0] GF_POLY_LO = 8'h1D;

  typedef logic [7:0] sbox_t [256];
  typedef logic [7:0] mds_t [8];

  // One item as it moves down the pipeline
  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic [63:0] lo;
    logic [63:0] hi;
  } item_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_ENC  = 1'b1;

  localparam mds_t MDS_V = '{8'h01, 8'h01, 8'h05, 8'h01, 8'h08, 8'h06, 8'h07, 8'h04};

  localparam sbox_t SBOX0 = '{
    8'ha8,8'h43,8'h5f,8'h06,8'h6b,8'h75,8'h6c,8'h59,8'h71,8'hdf,8'h87,8'h95,8'h17,8'hf0,8'hd8,8'h09,
    8'h6d,8'hf3,8'h1d,8'hcb,8'hc9,8'h4d,8'h2c,8'haf,8'h79,8'he0,8'h97,8'hfd,8'h6f,8'h4b,8'h45,8'h39,
    8'h3e,8'hdd,8'ha3,8'h4f,8'hb4,8'hb6,8'h9a,8'h0e,8'h1f,8'hbf,8'h15,8'he1,8'h49,8'hd2,8'h93,8'hc6,
    8'h92,8'h72,8'h9e,8'h61,8'hd1,8'h63,8'hfa,8'hee,8'hf4,8'h19,8'hd5,8'had,8'h58,8'ha4,8'hbb,8'ha1,
    8'hdc,8'hf2,8'h83,8'h37,8'h42,8'he4,8'h7a,8'h32,8'h9c,8'hcc,8'hab,8'h4a,8'h8f,8'h6e,8'h04,8'h27,
    8'h2e,8'he7,8'he2,8'h5a,8'h96,8'h16,8'h23,8'h2b,8'hc2,8'h65,8'h66,8'h0f,8'hbc,8'ha9,8'h47,8'h41,
    8'h34,8'h48,8'hfc,8'hb7,8'h6a,8'h88,8'ha5,8'h53,8'h86,8'hf9,8'h5b,8'hdb,8'h38,8'h7b,8'hc3,8'h1e,
    8'h22,8'h33,8'h24,8'h28,8'h36,8'hc7,8'hb2,8'h3b,8'h8e,8'h77,8'hba,8'hf5,8'h14,8'h9f,8'h08,8'h55,
    8'h9b,8'h4c,8'hfe,8'h60,8'h5c,8'hda,8'h18,8'h46,8'hcd,8'h7d,8'h21,8'hb0,8'h3f,8'h1b,8'h89,8'hff,
    8'heb,8'h84,8'h69,8'h3a,8'h9d,8'hd7,8'hd3,8'h70,8'h67,8'h40,8'hb5,8'hde,8'h5d,8'h30,8'h91,8'hb1,
    8'h78,8'h11,8'h01,8'he5,8'h00,8'h68,8'h98,8'ha0,8'hc5,8'h02,8'ha6,8'h74,8'h2d,8'h0b,8'ha2,8'h76,
    8'hb3,8'hbe,8'hce,8'hbd,8'hae,8'he9,8'h8a,8'h31,8'h1c,8'hec,8'hf1,8'h99,8'h94,8'haa,8'hf6,8'h26,
    8'h2f,8'hef,8'he8,8'h8c,8'h35,8'h03,8'hd4,8'h7f,8'hfb,8'h05,8'hc1,8'h5e,8'h90,8'h20,8'h3d,8'h82,
    8'hf7,8'hea,8'h0a,8'h0d,8'h7e,8'hf8,8'h50,8'h1a,8'hc4,8'h07,8'h57,8'hb8,8'h3c,8'h62,8'he3,8'hc8,
    8'hac,8'h52,8'h64,8'h10,8'hd0,8'hd9,8'h13,8'h0c,8'h12,8'h29,8'h51,8'hb9,8'hcf,8'hd6,8'h73,8'h8d,
    8'h81,8'h54,8'hc0,8'hed,8'h4e,8'h44,8'ha7,8'h2a,8'h85,8'h25,8'he6,8'hca,8'h7c,8'h8b,8'h56,8'h80
  };

  localparam sbox_t SBOX1 = '{
    8'hce,8'hbb,8'heb,8'h92,8'hea,8'hcb,8'h13,8'hc1,8'he9,8'h3a,8'hd6,8'hb2,8'hd2,8'h90,8'h17,8'hf8,
    8'h42,8'h15,8'h56,8'hb4,8'h65,8'h1c,8'h88,8'h43,8'hc5,8'h5c,8'h36,8'hba,8'hf5,8'h57,8'h67,8'h8d,
    8'h31,8'hf6,8'h64,8'h58,8'h9e,8'hf4,8'h22,8'haa,8'h75,8'h0f,8'h02,8'hb1,8'hdf,8'h6d,8'h73,8'h4d,
    8'h7c,8'h26,8'h2e,8'hf7,8'h08,8'h5d,8'h44,8'h3e,8'h9f,8'h14,8'hc8,8'hae,8'h54,8'h10,8'hd8,8'hbc,
    8'h1a,8'h6b,8'h69,8'hf3,8'hbd,8'h33,8'hab,8'hfa,8'hd1,8'h9b,8'h68,8'h4e,8'h16,8'h95,8'h91,8'hee,
    8'h4c,8'h63,8'h8e,8'h5b,8'hcc,8'h3c,8'h19,8'ha1,8'h81,8'h49,8'h7b,8'hd9,8'h6f,8'h37,8'h60,8'hca,
    8'he7,8'h2b,8'h48,8'hfd,8'h96,8'h45,8'hfc,8'h41,8'h12,8'h0d,8'h79,8'he5,8'h89,8'h8c,8'he3,8'h20,
    8'h30,8'hdc,8'hb7,8'h6c,8'h4a,8'hb5,8'h3f,8'h97,8'hd4,8'h62,8'h2d,8'h06,8'ha4,8'ha5,8'h83,8'h5f,
    8'h2a,8'hda,8'hc9,8'h00,8'h7e,8'ha2,8'h55,8'hbf,8'h11,8'hd5,8'h9c,8'hcf,8'h0e,8'h0a,8'h3d,8'h51,
    8'h7d,8'h93,8'h1b,8'hfe,8'hc4,8'h47,8'h09,8'h86,8'h0b,8'h8f,8'h9d,8'h6a,8'h07,8'hb9,8'hb0,8'h98,
    8'h18,8'h32,8'h71,8'h4b,8'hef,8'h3b,8'h70,8'ha0,8'he4,8'h40,8'hff,8'hc3,8'ha9,8'he6,8'h78,8'hf9,
    8'h8b,8'h46,8'h80,8'h1e,8'h38,8'he1,8'hb8,8'ha8,8'he0,8'h0c,8'h23,8'h76,8'h1d,8'h25,8'h24,8'h05,
    8'hf1,8'h6e,8'h94,8'h28,8'h9a,8'h84,8'he8,8'ha3,8'h4f,8'h77,8'hd3,8'h85,8'he2,8'h52,8'hf2,8'h82,
    8'h50,8'h7a,8'h2f,8'h74,8'h53,8'hb3,8'h61,8'haf,8'h39,8'h35,8'hde,8'hcd,8'h1f,8'h99,8'hac,8'had,
    8'h72,8'h2c,8'hdd,8'hd0,8'h87,8'hbe,8'h5e,8'ha6,8'hec,8'h04,8'hc6,8'h03,8'h34,8'hfb,8'hdb,8'h59,
    8'hb6,8'hc2,8'h01,8'hf0,8'h5a,8'hed,8'ha7,8'h66,8'h21,8'h7f,8'h8a,8'h27,8'hc7,8'hc0,8'h29,8'hd7
  };

  localparam sbox_t SBOX2 = '{
    8'h93,8'hd9,8'h9a,8'hb5,8'h98,8'h22,8'h45,8'hfc,8'hba,8'h6a,8'hdf,8'h02,8'h9f,8'hdc,8'h51,8'h59,
    8'h4a,8'h17,8'h2b,8'hc2,8'h94,8'hf4,8'hbb,8'ha3,8'h62,8'he4,8'h71,8'hd4,8'hcd,8'h70,8'h16,8'he1,
    8'h49,8'h3c,8'hc0,8'hd8,8'h5c,8'h9b,8'had,8'h85,8'h53,8'ha1,8'h7a,8'hc8,8'h2d,8'he0,8'hd1,8'h72,
    8'ha6,8'h2c,8'hc4,8'he3,8'h76,8'h78,8'hb7,8'hb4,8'h09,8'h3b,8'h0e,8'h41,8'h4c,8'hde,8'hb2,8'h90,
    8'h25,8'ha5,8'hd7,8'h03,8'h11,8'h00,8'hc3,8'h2e,8'h92,8'hef,8'h4e,8'h12,8'h9d,8'h7d,8'hcb,8'h35,
    8'h10,8'hd5,8'h4f,8'h9e,8'h4d,8'ha9,8'h55,8'hc6,8'hd0,8'h7b,8'h18,8'h97,8'hd3,8'h36,8'he6,8'h48,
    8'h56,8'h81,8'h8f,8'h77,8'hcc,8'h9c,8'hb9,8'he2,8'hac,8'hb8,8'h2f,8'h15,8'ha4,8'h7c,8'hda,8'h38,
    8'h1e,8'h0b,8'h05,8'hd6,8'h14,8'h6e,8'h6c,8'h7e,8'h66,8'hfd,8'hb1,8'he5,8'h60,8'haf,8'h5e,8'h33,
    8'h87,8'hc9,8'hf0,8'h5d,8'h6d,8'h3f,8'h88,8'h8d,8'hc7,8'hf7,8'h1d,8'he9,8'hec,8'hed,8'h80,8'h29,
    8'h27,8'hcf,8'h99,8'ha8,8'h50,8'h0f,8'h37,8'h24,8'h28,8'h30,8'h95,8'hd2,8'h3e,8'h5b,8'h40,8'h83,
    8'hb3,8'h69,8'h57,8'h1f,8'h07,8'h1c,8'h8a,8'hbc,8'h20,8'heb,8'hce,8'h8e,8'hab,8'hee,8'h31,8'ha2,
    8'h73,8'hf9,8'hca,8'h3a,8'h1a,8'hfb,8'h0d,8'hc1,8'hfe,8'hfa,8'hf2,8'h6f,8'hbd,8'h96,8'hdd,8'h43,
    8'h52,8'hb6,8'h08,8'hf3,8'hae,8'hbe,8'h19,8'h89,8'h32,8'h26,8'hb0,8'hea,8'h4b,8'h64,8'h84,8'h82,
    8'h6b,8'hf5,8'h79,8'hbf,8'h01,8'h5f,8'h75,8'h63,8'h1b,8'h23,8'h3d,8'h68,8'h2a,8'h65,8'he8,8'h91,
    8'hf6,8'hff,8'h13,8'h58,8'hf1,8'h47,8'h0a,8'h7f,8'hc5,8'ha7,8'he7,8'h61,8'h5a,8'h06,8'h46,8'h44,
    8'h42,8'h04,8'ha0,8'hdb,8'h39,8'h86,8'h54,8'haa,8'h8c,8'h34,8'h21,8'h8b,8'hf8,8'h0c,8'h74,8'h67
  };

  localparam sbox_t SBOX3 = '{
    8'h68,8'h8d,8'hca,8'h4d,8'h73,8'h4b,8'h4e,8'h2a,8'hd4,8'h52,8'h26,8'hb3,8'h54,8'h1e,8'h19,8'h1f,
    8'h22,8'h03,8'h46,8'h3d,8'h2d,8'h4a,8'h53,8'h83,8'h13,8'h8a,8'hb7,8'hd5,8'h25,8'h79,8'hf5,8'hbd,
    8'h58,8'h2f,8'h0d,8'h02,8'hed,8'h51,8'h9e,8'h11,8'hf2,8'h3e,8'h55,8'h5e,8'hd1,8'h16,8'h3c,8'h66,
    8'h70,8'h5d,8'hf3,8'h45,8'h40,8'hcc,8'he8,8'h94,8'h56,8'h08,8'hce,8'h1a,8'h3a,8'hd2,8'he1,8'hdf,
    8'hb5,8'h38,8'h6e,8'h0e,8'he5,8'hf4,8'hf9,8'h86,8'he9,8'h4f,8'hd6,8'h85,8'h23,8'hcf,8'h32,8'h99,
    8'h31,8'h14,8'hae,8'hee,8'hc8,8'h48,8'hd3,8'h30,8'ha1,8'h92,8'h41,8'hb1,8'h18,8'hc4,8'h2c,8'h71,
    8'h72,8'h44,8'h15,8'hfd,8'h37,8'hbe,8'h5f,8'haa,8'h9b,8'h88,8'hd8,8'hab,8'h89,8'h9c,8'hfa,8'h60,
    8'hea,8'hbc,8'h62,8'h0c,8'h24,8'ha6,8'ha8,8'hec,8'h67,8'h20,8'hdb,8'h7c,8'h28,8'hdd,8'hac,8'h5b,
    8'h34,8'h7e,8'h10,8'hf1,8'h7b,8'h8f,8'h63,8'ha0,8'h05,8'h9a,8'h43,8'h77,8'h21,8'hbf,8'h27,8'h09,
    8'hc3,8'h9f,8'hb6,8'hd7,8'h29,8'hc2,8'heb,8'hc0,8'ha4,8'h8b,8'h8c,8'h1d,8'hfb,8'hff,8'hc1,8'hb2,
    8'h97,8'h2e,8'hf8,8'h65,8'hf6,8'h75,8'h07,8'h04,8'h49,8'h33,8'he4,8'hd9,8'hb9,8'hd0,8'h42,8'hc7,
    8'h6c,8'h90,8'h00,8'h8e,8'h6f,8'h50,8'h01,8'hc5,8'hda,8'h47,8'h3f,8'hcd,8'h69,8'ha2,8'he2,8'h7a,
    8'ha7,8'hc6,8'h93,8'h0f,8'h0a,8'h06,8'he6,8'h2b,8'h96,8'ha3,8'h1c,8'haf,8'h6a,8'h12,8'h84,8'h39,
    8'he7,8'hb0,8'h82,8'hf7,8'hfe,8'h9d,8'h87,8'h5c,8'h81,8'h35,8'hde,8'hb4,8'ha5,8'hfc,8'h80,8'hef,
    8'hcb,8'hbb,8'h6b,8'h76,8'hba,8'h5a,8'h7d,8'h78,8'h0b,8'h95,8'he3,8'had,8'h74,8'h98,8'h3b,8'h36,
    8'h64,8'h6d,8'hdc,8'hf0,8'h59,8'ha9,8'h4c,8'h17,8'h7f,8'h91,8'hb8,8'hc9,8'h57,8'h1b,8'he0,8'h61
  };

  // Multiply in GF(2^8) modulo x^8+x^4+x^3+x^2+1; b is a constant at every call site
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x;
      x = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY_LO : 8'h00);
    end
    return acc;
  endfunction

  // S-boxes, row shift and MDS mix for one output column; own is this column, other the other
  function automatic logic [63:0] mix_col(input logic [63:0] own, input logic [63:0] other);
    logic [7:0]  sb [8];
    logic [7:0]  acc;
    logic [63:0] src;
    logic [63:0] res;
    res = '0;
    for (int j = 0; j < 8; j++) begin
      src = (j < 4) ? own : other;
      case (j & 3)
        0:       sb[j] = SBOX0[src[8*j +: 8]];
        1:       sb[j] = SBOX1[src[8*j +: 8]];
        2:       sb[j] = SBOX2[src[8*j +: 8]];
        default: sb[j] = SBOX3[src[8*j +: 8]];
      endcase
    end
    for (int r = 0; r < 8; r++) begin
      acc = 8'h00;
      for (int j = 0; j < 8; j++) begin
        acc = acc ^ gf_mul(sb[j], MDS_V[(j - r) & 7]);
      end
      res[8*r +: 8] = acc;
    end
    return res;
  endfunction

endpackage

// ----- rtl/kal_stage.sv -----
// One round stage of the encryption pipeline, with its own copy of the round key.
// Depends on kal_pkg (item_t, mix_col, ROUNDS).
module kal_stage #(
  parameter int STAGE_IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  input  kal_pkg::item_t up_item,
  output logic           up_ready,
  output logic           dn_valid,
  output kal_pkg::item_t dn_item,
  input  logic           dn_ready
);

  logic           valid_r;
  kal_pkg::item_t item_r;
  kal_pkg::item_t item_nxt;
  logic [63:0]    key_lo_r;
  logic [63:0]    key_hi_r;
  logic [63:0]    mix_lo;
  logic [63:0]    mix_hi;
  logic           take;
  logic           key_hit;

  assign up_ready = !valid_r || dn_ready;
  assign take     = up_valid && up_ready;
  assign key_hit  = (up_item.kind == kal_pkg::KIND_LOAD) &&
                    (up_item.slot == 4'(STAGE_IDX));

  // Round datapath: key add at the first stage, xor in the middle, add at the last
  always_comb begin
    mix_lo   = kal_pkg::mix_col(up_item.lo, up_item.hi);
    mix_hi   = kal_pkg::mix_col(up_item.hi, up_item.lo);
    item_nxt = up_item;
    if (up_item.kind == kal_pkg::KIND_ENC) begin
      if (STAGE_IDX == 0) begin
        item_nxt.lo = up_item.lo + key_lo_r;
        item_nxt.hi = up_item.hi + key_hi_r;
      end else if (STAGE_IDX == kal_pkg::ROUNDS) begin
        item_nxt.lo = mix_lo + key_lo_r;
        item_nxt.hi = mix_hi + key_hi_r;
      end else begin
        item_nxt.lo = mix_lo ^ key_lo_r;
        item_nxt.hi = mix_hi ^ key_hi_r;
      end
    end
  end

  // Hold the valid flag; drop it once the stage below has taken the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (dn_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Advance payload; a key load writes this stage's key as it passes
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
      if (key_hit) begin
        key_lo_r <= up_item.lo;
        key_hi_r <= up_item.hi;
      end
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

// ----- rtl/kalyna_128_block_encrypt.sv -----
// Top level of the Kalyna-128/128 block encryption pipeline.
// Depends on kal_pkg and kal_stage.
//
//  channel | direction | contents
//  in_     | slave     | tuser: kind; tdata: key_slot, data_lo, data_hi
//  out_    | master    | tdata: cipher_lo, cipher_hi
//
// Eleven register stages (key-0 add, then one per round); one item per cycle when not stalled.
// Key loads travel down the pipe; each writes the key copy of its slot's stage as it passes,
// so a load affects only blocks that follow it. Loads leave the last stage without a transfer.
// Each stage holds its item while the one below is full and stalled; bubbles close up.
// Reset clears every stage's valid flag; key copies are undefined until loaded.
module kalyna_128_block_encrypt (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // key_slot[3:0], data_lo[67:4], data_hi[131:68], zero pad
  input  logic         in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // cipher_lo[63:0], cipher_hi[127:64]
);

  localparam int NSTAGE = kal_pkg::ROUNDS + 1;

  logic           st_valid [NSTAGE+1];
  kal_pkg::item_t st_item  [NSTAGE+1];
  logic           st_ready [NSTAGE+1];

  // Unpack the input transfer
  assign st_valid[0]      = in_tvalid;
  assign st_item[0].kind  = in_tuser;
  assign st_item[0].slot  = in_tdata[3:0];
  assign st_item[0].lo    = in_tdata[67:4];
  assign st_item[0].hi    = in_tdata[131:68];
  assign in_tready        = st_ready[0];

  for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
    kal_stage #(.STAGE_IDX(g)) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_valid[g]),
      .up_item  (st_item[g]),
      .up_ready (st_ready[g]),
      .dn_valid (st_valid[g+1]),
      .dn_item  (st_item[g+1]),
      .dn_ready (st_ready[g+1])
    );
  end

  // Only blocks leave as transfers; key loads drain freely
  assign out_tvalid       = st_valid[NSTAGE] && (st_item[NSTAGE].kind == kal_pkg::KIND_ENC);
  assign st_ready[NSTAGE] = out_tready || (st_item[NSTAGE].kind == kal_pkg::KIND_LOAD);
  assign out_tdata        = {st_item[NSTAGE].hi, st_item[NSTAGE].lo};

endmodule

// ----- rtl/kal_checker.sv -----
// Port-level checks for the encryption pipeline, bound to the top level.
// Depends on kalyna_128_block_encrypt ports only.
module kal_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A free output side never blocks the input
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input blocked with output ready");

  // Input back-pressure comes only from a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input blocked without output stall");

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_tvalid)
    else $error("result present after reset");

endmodule

bind kalyna_128_block_encrypt kal_checker u_kal_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
